### sv/akl_pkg.sv
// types, token codes and keyword table for the assembly keyword lexer
package akl_pkg;

    localparam int KW_COUNT   = 14;
    localparam int KW_MAX_LEN = 5;
    localparam int KW_IDX_W   = $clog2(KW_MAX_LEN);
    localparam int QDEPTH     = 4;
    localparam int QPTR_W     = $clog2(QDEPTH);
    localparam int QCNT_W     = $clog2(QDEPTH + 1);

    localparam logic [4:0] KIND_EOF    = 5'd0;
    localparam logic [4:0] KIND_PLUS   = 5'd1;
    localparam logic [4:0] KIND_MINUS  = 5'd2;
    localparam logic [4:0] KIND_NUMBER = 5'd3;
    localparam logic [4:0] KIND_LABEL  = 5'd4;
    localparam logic [4:0] KIND_ERROR  = 5'd5;
    localparam logic [4:0] KIND_KW0    = 5'd6;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0a;
    localparam logic [7:0] CH_CR    = 8'h0d;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2b;
    localparam logic [7:0] CH_MINUS = 8'h2d;
    localparam logic [7:0] CH_DOT   = 8'h2e;
    localparam logic [7:0] CH_COLON = 8'h3a;
    localparam logic [7:0] CH_UNDER = 8'h5f;

    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_INT,
        MODE_FRAC,
        MODE_WORD,
        MODE_LONG
    } lex_mode_t;

    typedef struct packed {
        logic [4:0]  kind;
        logic [15:0] tbegin;
        logic [7:0]  len;
        logic [15:0] line;
        logic        last;
    } token_t;

    // first character in the top byte, unused bytes zero
    localparam logic [8*KW_MAX_LEN-1:0] KW_TEXT [KW_COUNT] = '{
        {"acc", 16'h0}, {"dat", 16'h0}, {"mov", 16'h0}, 40'h73746f7574,
        {"stin", 8'h0}, {"add", 16'h0}, {"sub", 16'h0}, {"mul", 16'h0},
        {"div", 16'h0}, {"teq", 16'h0}, {"tgt", 16'h0}, {"tlt", 16'h0},
        {"tcp", 16'h0}, {"jmp", 16'h0}
    };

    localparam logic [2:0] KW_LEN [KW_COUNT] = '{
        3'd3, 3'd3, 3'd3, 3'd5, 3'd4, 3'd3, 3'd3,
        3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3
    };

    function automatic logic [7:0] kw_char(input int k, input int i);
        return KW_TEXT[k][8*(KW_MAX_LEN-1-i) +: 8];
    endfunction

endpackage

### sv/assembly_keyword_lexer.sv
// assembly keyword lexer: one source byte per request, tokens out through a queue
// an accepted byte waits in the input stage; its tokens are queued once there is room
// throughput: one byte per cycle while no byte gives two tokens and out_stall is low
// a byte that ends a pending token and is a token itself gives two, drained one per
//   cycle unless out_stall via the four-entry queue; the input stalls at three or more
// reset: lexer idle, offsets and lengths zero, line one, queue and input stage empty
module assembly_keyword_lexer #(
    parameter int MAX_WORD_LEN = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  char_code,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [4:0]  token_kind,
    output logic [15:0] token_begin,
    output logic [7:0]  token_len,
    output logic [15:0] line_no,
    output logic        last_of_run
);
    import akl_pkg::*;

    localparam int CNT_W = $clog2(MAX_WORD_LEN + 1);

    logic              full_reg, full_next;
    logic [7:0]        char_reg;
    lex_mode_t         mode_reg, mode_next;
    logic [7:0]        word_reg [KW_MAX_LEN];
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [15:0]       begin_reg, begin_next;
    logic [15:0]       offset_reg, offset_next;
    logic [15:0]       line_reg, line_next;
    logic [7:0]        run_reg, run_next;

    token_t            q_reg [QDEPTH];
    logic [QPTR_W-1:0] head_reg, tail_reg;
    logic [QCNT_W-1:0] qcnt_reg;

    logic              proc, pop;
    logic              is_dig, is_let, is_ws;
    logic [15:0]       offset_inc, line_inc;
    logic [7:0]        run_inc;
    logic              kw_hit;
    logic [4:0]        kw_kind;

    logic              extend, go_idle, to_label;
    logic              pend_v, idle_v;
    token_t            pend_tok, idle_tok, tok0, tok1;
    logic [1:0]        push_n;
    logic              wr_en;
    logic [KW_IDX_W-1:0] wr_idx;

    assign proc     = full_reg && (qcnt_reg <= QCNT_W'(QDEPTH - 2));
    assign in_stall = full_reg && !proc;
    assign full_next = (in_valid && !in_stall) ? 1'b1 : (proc ? 1'b0 : full_reg);

    assign is_dig = (char_reg >= "0") && (char_reg <= "9");
    assign is_let = ((char_reg >= "a") && (char_reg <= "z"))
                 || ((char_reg >= "A") && (char_reg <= "Z")) || (char_reg == CH_UNDER);
    assign is_ws  = (char_reg == CH_SPACE) || (char_reg == CH_TAB) || (char_reg == CH_CR);

    assign offset_inc = (offset_reg != 16'hffff) ? offset_reg + 16'd1 : offset_reg;
    assign line_inc   = (line_reg != 16'hffff) ? line_reg + 16'd1 : line_reg;
    assign run_inc    = (run_reg != 8'hff) ? run_reg + 8'd1 : run_reg;

    always_comb
    begin
        kw_hit  = 1'b0;
        kw_kind = KIND_ERROR;
        for (int k = 0; k < KW_COUNT; k++)
        begin
            logic m;
            m = (count_reg == CNT_W'(KW_LEN[k]));
            for (int i = 0; i < KW_MAX_LEN; i++)
            begin
                if (i < int'(KW_LEN[k]) && word_reg[i] != kw_char(k, i))
                begin
                    m = 1'b0;
                end
            end
            if (m && !kw_hit)
            begin
                kw_hit  = 1'b1;
                kw_kind = KIND_KW0 + 5'(k);
            end
        end
    end

    // mode decode and token outputs
    always_comb
    begin
        extend   = 1'b0;
        go_idle  = 1'b0;
        to_label = 1'b0;
        pend_v   = 1'b0;
        pend_tok = '{kind: KIND_ERROR, tbegin: begin_reg, len: run_reg, line: line_reg,
                     last: 1'b0};
        case (mode_reg)
            MODE_INT:
            begin
                if (is_dig || char_reg == CH_DOT)
                begin
                    extend = 1'b1;
                end
                else
                begin
                    pend_v        = 1'b1;
                    pend_tok.kind = KIND_NUMBER;
                    go_idle       = 1'b1;
                end
            end
            MODE_FRAC:
            begin
                if (is_dig)
                begin
                    extend = 1'b1;
                end
                else
                begin
                    pend_v        = 1'b1;
                    pend_tok.kind = KIND_NUMBER;
                    go_idle       = 1'b1;
                end
            end
            MODE_WORD:
            begin
                if (is_let)
                begin
                    extend = 1'b1;
                end
                else if (kw_hit)
                begin
                    pend_v        = 1'b1;
                    pend_tok.kind = kw_kind;
                    go_idle       = 1'b1;
                end
                else if (char_reg == CH_COLON)
                begin
                    pend_v        = 1'b1;
                    pend_tok.kind = KIND_LABEL;
                    pend_tok.len  = run_inc;
                    to_label      = 1'b1;
                end
                else
                begin
                    pend_v  = 1'b1;
                    go_idle = 1'b1;
                end
            end
            MODE_LONG:
            begin
                if (is_let)
                begin
                    extend = 1'b1;
                end
                else
                begin
                    pend_v  = 1'b1;
                    go_idle = 1'b1;
                end
            end
            default:
            begin
                go_idle = 1'b1;
            end
        endcase

        idle_v   = 1'b0;
        idle_tok = '{kind: KIND_ERROR, tbegin: offset_reg, len: 8'd1, line: line_reg,
                     last: 1'b1};
        if (go_idle)
        begin
            if (char_reg == CH_NUL)
            begin
                idle_v       = 1'b1;
                idle_tok.kind = KIND_EOF;
                idle_tok.len  = 8'd0;
            end
            else if (char_reg == CH_PLUS)
            begin
                idle_v        = 1'b1;
                idle_tok.kind = KIND_PLUS;
            end
            else if (char_reg == CH_MINUS)
            begin
                idle_v        = 1'b1;
                idle_tok.kind = KIND_MINUS;
            end
            else if (!is_ws && char_reg != CH_LF && !is_dig && !is_let)
            begin
                idle_v = 1'b1;
            end
        end
        pend_tok.last = !idle_v;

        tok0   = pend_v ? pend_tok : idle_tok;
        tok1   = idle_tok;
        push_n = proc ? (2'(pend_v) + 2'(idle_v)) : 2'd0;
    end

    // next state
    always_comb
    begin
        mode_next   = mode_reg;
        count_next  = count_reg;
        begin_next  = begin_reg;
        offset_next = offset_reg;
        line_next   = line_reg;
        run_next    = run_reg;
        wr_en       = 1'b0;
        wr_idx      = count_reg[KW_IDX_W-1:0];
        if (proc)
        begin
            if (extend)
            begin
                run_next    = run_inc;
                offset_next = offset_inc;
                if (mode_reg == MODE_INT && char_reg == CH_DOT)
                begin
                    mode_next = MODE_FRAC;
                end
                else if (mode_reg == MODE_WORD)
                begin
                    if (count_reg < CNT_W'(MAX_WORD_LEN))
                    begin
                        count_next = count_reg + CNT_W'(1);
                        wr_en      = (count_reg < CNT_W'(KW_MAX_LEN));
                    end
                    else
                    begin
                        mode_next = MODE_LONG;
                    end
                end
            end
            else if (to_label)
            begin
                run_next    = run_inc;
                offset_next = offset_inc;
                mode_next   = MODE_IDLE;
            end
            else if (go_idle)
            begin
                mode_next = MODE_IDLE;
                if (char_reg != CH_NUL)
                begin
                    offset_next = offset_inc;
                end
                if (char_reg == CH_LF)
                begin
                    line_next = line_inc;
                end
                if (is_dig || is_let)
                begin
                    begin_next = offset_reg;
                    run_next   = 8'd1;
                    mode_next  = is_dig ? MODE_INT : MODE_WORD;
                end
                if (is_let)
                begin
                    count_next = CNT_W'(1);
                    wr_en      = 1'b1;
                    wr_idx     = '0;
                end
            end
        end
    end

    assign pop = (qcnt_reg != '0) && !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_reg   <= 1'b0;
            mode_reg   <= MODE_IDLE;
            count_reg  <= '0;
            begin_reg  <= 16'd0;
            offset_reg <= 16'd0;
            line_reg   <= 16'd1;
            run_reg    <= 8'd0;
            head_reg   <= '0;
            tail_reg   <= '0;
            qcnt_reg   <= '0;
        end
        else
        begin
            full_reg   <= full_next;
            mode_reg   <= mode_next;
            count_reg  <= count_next;
            begin_reg  <= begin_next;
            offset_reg <= offset_next;
            line_reg   <= line_next;
            run_reg    <= run_next;
            tail_reg   <= tail_reg + QPTR_W'(push_n);
            if (pop)
            begin
                head_reg <= head_reg + QPTR_W'(1);
            end
            qcnt_reg   <= qcnt_reg + QCNT_W'(push_n) - QCNT_W'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            char_reg <= char_code;
        end
        if (wr_en)
        begin
            word_reg[wr_idx] <= char_reg;
        end
        if (push_n != 2'd0)
        begin
            q_reg[tail_reg] <= tok0;
        end
        if (push_n == 2'd2)
        begin
            q_reg[tail_reg + QPTR_W'(1)] <= tok1;
        end
    end

    assign out_valid   = (qcnt_reg != '0);
    assign token_kind  = q_reg[head_reg].kind;
    assign token_begin = q_reg[head_reg].tbegin;
    assign token_len   = q_reg[head_reg].len;
    assign line_no     = q_reg[head_reg].line;
    assign last_of_run = q_reg[head_reg].last;

endmodule

### test/tb.sv
// self-checking testbench for the assembly keyword lexer
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import akl_pkg::*;

    localparam int WORD_MAX     = 8;
    localparam int RANDOM_ITEMS = 350;
    localparam int TAIL_ITEMS   = 40;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 20;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int DIRECTED_N   = 27;

    typedef struct packed {
        logic [7:0] ch;
        logic       has_tok;
        token_t     tok;
    } stim_row_t;

    localparam stim_row_t DIRECTED [DIRECTED_N] = '{
        '{CH_PLUS,  1'b1, '{KIND_PLUS,   16'd0,  8'd1, 16'd1, 1'b1}},
        '{CH_MINUS, 1'b1, '{KIND_MINUS,  16'd1,  8'd1, 16'd1, 1'b1}},
        '{CH_LF,    1'b0, '0},
        '{CH_COLON, 1'b1, '{KIND_ERROR,  16'd3,  8'd1, 16'd2, 1'b1}},
        '{8'hff,    1'b1, '{KIND_ERROR,  16'd4,  8'd1, 16'd2, 1'b1}},
        '{CH_TAB,   1'b0, '0},
        '{"9",      1'b0, '0},
        '{CH_DOT,   1'b0, '0},
        '{"0",      1'b0, '0},
        '{"j",      1'b1, '{KIND_NUMBER, 16'd6,  8'd3, 16'd2, 1'b1}},
        '{"m",      1'b0, '0},
        '{"p",      1'b0, '0},
        '{CH_COLON, 1'b0, '0},
        '{"Z",      1'b0, '0},
        '{CH_UNDER, 1'b0, '0},
        '{CH_COLON, 1'b1, '{KIND_LABEL,  16'd13, 8'd3, 16'd2, 1'b1}},
        '{CH_CR,    1'b0, '0},
        '{"q",      1'b0, '0},
        '{"q",      1'b0, '0},
        '{"q",      1'b0, '0},
        '{"q",      1'b0, '0},
        '{"q",      1'b0, '0},
        '{"q",      1'b0, '0},
        '{"q",      1'b0, '0},
        '{"q",      1'b0, '0},
        '{"q",      1'b0, '0},
        '{CH_NUL,   1'b0, '0}
    };

    logic        clk;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic        in_stall;
    logic [7:0]  char_code = 8'h00;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [4:0]  token_kind;
    logic [15:0] token_begin;
    logic [7:0]  token_len;
    logic [15:0] line_no;
    logic        last_of_run;

    lex_mode_t   scan_mode;
    logic [7:0]  word_buf [WORD_MAX];
    int          word_len;
    logic [15:0] tok_start;
    logic [15:0] char_pos;
    logic [15:0] cur_line;
    logic [7:0]  tok_len;
    string       kw_names [KW_COUNT];

    token_t      char_tokens [$];
    token_t      pending_tokens [$];
    logic [7:0]  src_q [$];

    bit          calm      = 1'b0;
    bit          hold_req  = 1'b0;
    int          mismatches = 0;
    int          cycles    = 0;

    assembly_keyword_lexer #(.MAX_WORD_LEN(WORD_MAX)) DUT (
        .clk,
        .rst_n,
        .in_valid,
        .in_stall,
        .char_code,
        .out_valid,
        .out_stall,
        .token_kind,
        .token_begin,
        .token_len,
        .line_no,
        .last_of_run
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic bit is_num_char(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic bit is_letter(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == CH_UNDER;
    endfunction

    function automatic bit is_space(input logic [7:0] c);
        return c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_LF;
    endfunction

    function automatic void advance();
        if (char_pos != 16'hffff)
            char_pos++;
    endfunction

    function automatic void lengthen();
        if (tok_len != 8'hff)
            tok_len++;
    endfunction

    function automatic void add_token(input logic [4:0] kind, input logic [15:0] b,
                                      input logic [7:0] n);
        token_t t;
        t.kind   = kind;
        t.tbegin = b;
        t.len    = n;
        t.line   = cur_line;
        t.last   = 1'b0;
        char_tokens.push_back(t);
    endfunction

    function automatic int keyword_index();
        int k;
        int i;
        bit same;
        for (k = 0; k < KW_COUNT; k++)
        begin
            if (kw_names[k].len() == word_len)
            begin
                same = 1'b1;
                for (i = 0; i < word_len; i++)
                    if (kw_names[k][i] != word_buf[i])
                        same = 1'b0;
                if (same)
                    return k;
            end
        end
        return -1;
    endfunction

    function automatic void lex_idle(input logic [7:0] c);
        scan_mode = MODE_IDLE;
        if (c == CH_NUL)
            add_token(KIND_EOF, char_pos, 8'd0);
        else if (c == CH_SPACE || c == CH_TAB || c == CH_CR)
            advance();
        else if (c == CH_LF)
        begin
            if (cur_line != 16'hffff)
                cur_line++;
            advance();
        end
        else if (c == CH_PLUS || c == CH_MINUS)
        begin
            add_token(c == CH_PLUS ? KIND_PLUS : KIND_MINUS, char_pos, 8'd1);
            advance();
        end
        else if (is_num_char(c))
        begin
            tok_start = char_pos;
            tok_len   = 8'd1;
            scan_mode = MODE_INT;
            advance();
        end
        else if (is_letter(c))
        begin
            tok_start   = char_pos;
            tok_len     = 8'd1;
            word_buf[0] = c;
            word_len    = 1;
            scan_mode   = MODE_WORD;
            advance();
        end
        else
        begin
            add_token(KIND_ERROR, char_pos, 8'd1);
            advance();
        end
    endfunction

    function automatic void lex_char(input logic [7:0] c);
        int kw;
        char_tokens.delete();
        case (scan_mode)
            MODE_INT:
            begin
                if (is_num_char(c))
                begin
                    lengthen();
                    advance();
                end
                else if (c == CH_DOT)
                begin
                    lengthen();
                    advance();
                    scan_mode = MODE_FRAC;
                end
                else
                begin
                    add_token(KIND_NUMBER, tok_start, tok_len);
                    lex_idle(c);
                end
            end
            MODE_FRAC:
            begin
                if (is_num_char(c))
                begin
                    lengthen();
                    advance();
                end
                else
                begin
                    add_token(KIND_NUMBER, tok_start, tok_len);
                    lex_idle(c);
                end
            end
            MODE_WORD:
            begin
                if (is_letter(c))
                begin
                    if (word_len < WORD_MAX)
                    begin
                        word_buf[word_len] = c;
                        word_len++;
                    end
                    else
                        scan_mode = MODE_LONG;
                    lengthen();
                    advance();
                end
                else
                begin
                    kw = keyword_index();
                    if (kw >= 0)
                    begin
                        add_token(KIND_KW0 + 5'(kw), tok_start, tok_len);
                        lex_idle(c);
                    end
                    else if (c == CH_COLON)
                    begin
                        lengthen();
                        add_token(KIND_LABEL, tok_start, tok_len);
                        advance();
                        scan_mode = MODE_IDLE;
                    end
                    else
                    begin
                        add_token(KIND_ERROR, tok_start, tok_len);
                        lex_idle(c);
                    end
                end
            end
            MODE_LONG:
            begin
                if (is_letter(c))
                begin
                    lengthen();
                    advance();
                end
                else
                begin
                    add_token(KIND_ERROR, tok_start, tok_len);
                    lex_idle(c);
                end
            end
            default:
                lex_idle(c);
        endcase
        if (char_tokens.size() != 0)
            char_tokens[char_tokens.size() - 1].last = 1'b1;
    endfunction

    function automatic logic [7:0] rand_letter();
        int r;
        r = $urandom_range(52);
        if (r < 26)
            return 8'("a" + r);
        else if (r < 52)
            return 8'("A" + r - 26);
        return CH_UNDER;
    endfunction

    function automatic logic [7:0] rand_digit();
        return 8'("0" + $urandom_range(9));
    endfunction

    function automatic logic [7:0] rand_space();
        case ($urandom_range(3))
            0:       return CH_SPACE;
            1:       return CH_TAB;
            2:       return CH_CR;
            default: return CH_LF;
        endcase
    endfunction

    function automatic void put_letters(input int n);
        repeat (n) src_q.push_back(rand_letter());
    endfunction

    function automatic void put_digits(input int n);
        repeat (n) src_q.push_back(rand_digit());
    endfunction

    // one piece of source text, mostly well formed
    function automatic void queue_lexeme();
        int r;
        int i;
        int k;
        r = $urandom_range(99);
        if (r < 25)
        begin
            k = $urandom_range(KW_COUNT - 1);
            for (i = 0; i < kw_names[k].len(); i++)
                src_q.push_back(kw_names[k][i]);
            if ($urandom_range(99) < 15)
                src_q.push_back(CH_COLON);
        end
        else if (r < 37)
        begin
            put_letters($urandom_range(WORD_MAX, 1));
            src_q.push_back(CH_COLON);
        end
        else if (r < 45)
            put_letters($urandom_range(WORD_MAX, 1));
        else if (r < 50)
        begin
            put_letters($urandom_range(WORD_MAX + 12, WORD_MAX + 1));
            if ($urandom_range(99) < 30)
                src_q.push_back(CH_COLON);
        end
        else if (r < 65)
        begin
            put_digits($urandom_range(4, 1));
            if ($urandom_range(1))
            begin
                src_q.push_back(CH_DOT);
                put_digits($urandom_range(3, 0));
            end
        end
        else if (r < 72)
            src_q.push_back($urandom_range(1) ? CH_PLUS : CH_MINUS);
        else if (r < 75)
            src_q.push_back(CH_NUL);
        else if (r < 82)
            src_q.push_back(8'($urandom_range(255)));
        else if (r < 86)
            src_q.push_back(8'($urandom_range(255, 128)));
        else
            src_q.push_back(rand_space());
        if ($urandom_range(99) < 60)
            src_q.push_back(rand_space());
    endfunction

    task automatic send_char(input logic [7:0] c, input logic has_tok = 1'b0,
                             input token_t tok = '0);
        while (!calm && $urandom_range(99) < 35)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        char_code <= c;
        do @(posedge clk); while (in_stall);
        lex_char(c);
        if (has_tok)
            char_tokens = '{tok};
        foreach (char_tokens[i])
            pending_tokens.push_back(char_tokens[i]);
    endtask

    task automatic send_random(input int n, input bit pressure);
        int         counted;
        bit         held;
        bit         paused;
        logic [7:0] c;
        counted = 0;
        held    = 1'b0;
        paused  = 1'b0;
        src_q.delete();
        while (counted < n)
        begin
            if (src_q.size() == 0)
                queue_lexeme();
            c = src_q.pop_front();
            if (pressure)
            begin
                if (!held && counted == 50)
                begin
                    hold_req = 1'b1;
                    held     = 1'b1;
                end
                calm = counted >= 150 && counted < 250;
                if (!paused && counted == 300)
                begin
                    paused   = 1'b1;
                    in_valid <= 1'b0;
                    do @(posedge clk); while (pending_tokens.size() != 0);
                end
            end
            send_char(c);
            if (!is_space(c))
                counted++;
        end
        calm = 1'b0;
    endtask

    function automatic void check_field(input string name, input logic [15:0] want,
                                        input logic [15:0] got);
        if (got !== want)
        begin
            mismatches++;
            $display("%0t %s: expected %0d, actual %0d", $time, name, want, got);
        end
    endfunction

    always @(posedge clk)
    begin
        token_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_tokens.size() == 0)
            begin
                mismatches++;
                $display("%0t unexpected token: expected none, actual kind %0d begin %0d",
                         $time, token_kind, token_begin);
            end
            else
            begin
                want = pending_tokens.pop_front();
                check_field("token_kind", 16'(want.kind), 16'(token_kind));
                check_field("token_begin", want.tbegin, token_begin);
                check_field("token_len", 16'(want.len), 16'(token_len));
                check_field("line_no", want.line, line_no);
                check_field("last_of_run", 16'(want.last), 16'(last_of_run));
            end
        end
    end

    // result side: random stall, one long hold-off on request
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
                out_stall <= !calm && $urandom_range(99) < 35;
        end
    end

    initial
    begin
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        kw_names = '{"acc", "dat", "mov", {"st", "out"}, "stin", "add", "sub",
                     "mul", "div", "teq", "tgt", "tlt", "tcp", "jmp"};
        scan_mode = MODE_IDLE;
        word_len  = 0;
        tok_start = 16'd0;
        char_pos  = 16'd0;
        cur_line  = 16'd1;
        tok_len   = 8'd0;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < DIRECTED_N; i++)
            send_char(DIRECTED[i].ch, DIRECTED[i].has_tok, DIRECTED[i].tok);

        send_random(RANDOM_ITEMS, 1'b1);

        // saturate the token length counter
        repeat (260) send_char(rand_letter());
        send_char(CH_SPACE);

        send_random(TAIL_ITEMS, 1'b0);
        send_char(CH_NUL);

        in_valid <= 1'b0;
        while (pending_tokens.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
